[rtl/core/sptq_pkg.sv]
package sptq_pkg;

  localparam int unsigned LevelsDefault     = 4;
  localparam int unsigned LevelDepthDefault = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned HandleW = 16;
  localparam int unsigned PrioW   = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TotalW  = 7;
  localparam int unsigned CountW  = 32;

  localparam logic [KindW-1:0] KindAdd    = 2'd0;
  localparam logic [KindW-1:0] KindTake   = 2'd1;
  localparam logic [KindW-1:0] KindCancel = 2'd2;
  localparam logic [KindW-1:0] KindStop   = 2'd3;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StBadLevel  = 3'd1;
  localparam logic [StatusW-1:0] StStopped   = 3'd2;
  localparam logic [StatusW-1:0] StNotQueued = 3'd3;
  localparam logic [StatusW-1:0] StEmpty     = 3'd4;
  localparam logic [StatusW-1:0] StFull      = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic decide;    // resolve the item that needs no search
    logic scan;      // read one slot
    logic check;     // compare the slot just read
    logic shift;     // move one slot down while compacting
    logic finish;    // close a removal and publish the result
    logic miss;      // publish a not-in-queue result
  } sptq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search;  // item is a take or cancel that touches memory
    logic hit;          // slot just read matches, or the item is a take
    logic scan_last;    // the slot at the current position is the last held one
    logic shift_last;   // this shift moves the last held slot
  } sptq_stat_t;

endpackage

[rtl/core/sptq_ctrl.sv]
module sptq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   out_valid_i,
  output sptq_pkg::sptq_cmd_t    cmd_o,
  input  sptq_pkg::sptq_stat_t   stat_i
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SScan   = 3'd2;
  localparam logic [2:0] SCheck  = 3'd3;
  localparam logic [2:0] SShift  = 3'd4;
  localparam logic [2:0] SWait   = 3'd5;

  logic [2:0] state_q, state_d;

  // A new item is taken only when idle and the output register is free.
  assign in_ready_o = (state_q == SIdle) && !out_valid_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = SDecide;
        end
      end
      SDecide: begin
        if (stat_i.need_search) begin
          state_d = SScan;
        end else begin
          cmd_o.decide = 1'b1;
          state_d      = SWait;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        state_d    = SCheck;
      end
      SCheck: begin
        cmd_o.check = 1'b1;
        if (stat_i.hit) begin
          if (stat_i.scan_last) begin
            cmd_o.finish = 1'b1;
            state_d      = SWait;
          end else begin
            state_d = SShift;
          end
        end else if (stat_i.scan_last) begin
          cmd_o.miss = 1'b1;
          state_d    = SWait;
        end else begin
          state_d = SScan;
        end
      end
      SShift: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_last) begin
          cmd_o.finish = 1'b1;
          state_d      = SWait;
        end
      end
      SWait: begin
        if (!out_valid_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // A publish command leads to the wait state; load only when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.finish || cmd_o.miss || cmd_o.decide) |=> state_q == SWait)
    else $error("result command did not lead to the wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == SIdle)
    else $error("item loaded outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.finish, cmd_o.miss, cmd_o.decide}) <= 1)
    else $error("more than one result command");

endmodule

[rtl/core/sptq_datapath.sv]
module sptq_datapath #(
  parameter int unsigned Levels     = sptq_pkg::LevelsDefault,
  parameter int unsigned LevelDepth = sptq_pkg::LevelDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sptq_pkg::sptq_cmd_t           cmd_i,
  output sptq_pkg::sptq_stat_t          stat_o,
  input  logic [sptq_pkg::KindW-1:0]    kind_i,
  input  logic [sptq_pkg::HandleW-1:0]  task_handle_i,
  input  logic [sptq_pkg::PrioW-1:0]    priority_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sptq_pkg::StatusW-1:0]  status_o,
  output logic [sptq_pkg::HandleW-1:0]  taken_handle_o,
  output logic [sptq_pkg::TotalW-1:0]   queued_total_o,
  output logic [sptq_pkg::CountW-1:0]   added_count_o
);

  localparam int unsigned LvW   = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PosW  = (LevelDepth > 1) ? $clog2(LevelDepth) : 1;
  localparam int unsigned FillW = $clog2(LevelDepth + 1);
  localparam int unsigned AddrW = LvW + PosW;
  localparam int unsigned Words = Levels * (2 ** PosW);

  // Slot memory: row per level, one word per position.
  logic [sptq_pkg::HandleW-1:0] mem_q [Words];
  logic [sptq_pkg::HandleW-1:0] rd_q;

  logic [FillW-1:0]             fill_q [Levels];
  logic [sptq_pkg::TotalW-1:0]  total_q;
  logic [sptq_pkg::CountW-1:0]  adds_q;
  logic                         stopped_q;

  logic [sptq_pkg::KindW-1:0]   kind_q;
  logic [sptq_pkg::HandleW-1:0] handle_q;
  logic [sptq_pkg::PrioW-1:0]   prio_q;
  logic [LvW-1:0]               lv_q;
  logic [PosW-1:0]              pos_q;
  logic [sptq_pkg::HandleW-1:0] first_q;

  // Level decode for the captured item.
  logic             prio_ok;
  logic [LvW-1:0]   prio_lv;
  logic             any_held;
  logic [LvW-1:0]   first_lv;
  logic [FillW-1:0] cur_fill;
  logic [FillW-1:0] pos_ext;
  logic             hit;

  assign prio_ok = ({28'd0, prio_q} < Levels);
  assign prio_lv = prio_q[LvW-1:0];

  // Lowest-numbered level that holds something.
  always_comb begin
    any_held = 1'b0;
    first_lv = '0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        any_held = 1'b1;
        first_lv = LvW'(i);
      end
    end
  end

  assign cur_fill = fill_q[lv_q];
  assign pos_ext  = FillW'(pos_q);
  assign hit      = (rd_q == handle_q) || (kind_q == sptq_pkg::KindTake);

  always_comb begin
    stat_o             = '0;
    stat_o.need_search = ((kind_q == sptq_pkg::KindTake) && any_held) ||
                         ((kind_q == sptq_pkg::KindCancel) && prio_ok &&
                          (fill_q[prio_lv] != '0));
    stat_o.hit         = hit;
    stat_o.scan_last   = (pos_ext + FillW'(1)) >= cur_fill;
    stat_o.shift_last  = (pos_ext + FillW'(1)) >= (cur_fill - FillW'(1));
  end

  // Memory write on add and shift; registered read on scan, hit and shift.
  // Compaction keeps the next slot prefetched in the read register.
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] nx1_addr;
  logic [AddrW-1:0] nx2_addr;
  assign rd_addr  = {lv_q, pos_q};
  assign nx1_addr = {lv_q, pos_q + PosW'(1)};
  assign nx2_addr = {lv_q, pos_q + PosW'(2)};

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [sptq_pkg::HandleW-1:0] wr_data;
  logic             add_ok;
  assign add_ok = cmd_i.decide && (kind_q == sptq_pkg::KindAdd) && prio_ok &&
                  !stopped_q && (fill_q[prio_lv] < FillW'(LevelDepth));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = handle_q;
    if (add_ok) begin
      wr_en   = 1'b1;
      wr_addr = {prio_lv, fill_q[prio_lv][PosW-1:0]};
    end else if (cmd_i.shift) begin
      wr_en   = 1'b1;
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.scan) begin
      rd_q <= mem_q[rd_addr];
    end else if (cmd_i.check && hit) begin
      rd_q <= mem_q[nx1_addr];
    end else if (cmd_i.shift) begin
      rd_q <= mem_q[nx2_addr];
    end
  end

  // Item capture and scan position. The level is fixed at load, since the
  // fill counts cannot change before the first scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= '0;
      handle_q <= '0;
      prio_q   <= '0;
      lv_q     <= '0;
      pos_q    <= '0;
      first_q  <= '0;
    end else if (cmd_i.load) begin
      kind_q   <= kind_i;
      handle_q <= task_handle_i;
      prio_q   <= priority_level_i;
      lv_q     <= (kind_i == sptq_pkg::KindTake) ? first_lv : priority_level_i[LvW-1:0];
      pos_q    <= '0;
    end else if (cmd_i.check) begin
      if (hit) begin
        first_q <= rd_q;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end else if (cmd_i.shift) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  // Next values of the persistent state and of the result.
  logic                         res_load;
  logic [sptq_pkg::StatusW-1:0] res_status;
  logic [sptq_pkg::HandleW-1:0] res_taken;
  logic [sptq_pkg::TotalW-1:0]  total_d;
  logic [sptq_pkg::CountW-1:0]  adds_d;
  logic                         stopped_d;
  logic                         fill_we;
  logic [LvW-1:0]               fill_lv;
  logic [FillW-1:0]             fill_wd;

  always_comb begin
    res_load   = cmd_i.decide || cmd_i.miss || cmd_i.finish;
    res_status = sptq_pkg::StOk;
    res_taken  = '0;
    total_d    = total_q;
    adds_d     = adds_q;
    stopped_d  = stopped_q;
    fill_we    = 1'b0;
    fill_lv    = prio_lv;
    fill_wd    = '0;
    if (cmd_i.decide) begin
      unique case (kind_q)
        sptq_pkg::KindAdd: begin
          if (!prio_ok) begin
            res_status = sptq_pkg::StBadLevel;
          end else if (stopped_q) begin
            res_status = sptq_pkg::StStopped;
          end else if (!add_ok) begin
            res_status = sptq_pkg::StFull;
          end else begin
            fill_we = 1'b1;
            fill_wd = fill_q[prio_lv] + FillW'(1);
            total_d = total_q + sptq_pkg::TotalW'(1);
            adds_d  = adds_q + sptq_pkg::CountW'(1);
          end
        end
        sptq_pkg::KindTake:   res_status = sptq_pkg::StEmpty;
        sptq_pkg::KindCancel: res_status = prio_ok ? sptq_pkg::StNotQueued
                                                   : sptq_pkg::StBadLevel;
        default:              stopped_d = 1'b1;
      endcase
    end else if (cmd_i.miss) begin
      res_status = sptq_pkg::StNotQueued;
    end else if (cmd_i.finish) begin
      // A take from a level of one finishes in the compare cycle itself.
      if (kind_q == sptq_pkg::KindTake) begin
        res_taken = cmd_i.check ? rd_q : first_q;
      end
      fill_we = 1'b1;
      fill_lv = lv_q;
      fill_wd = cur_fill - FillW'(1);
      total_d = total_q - sptq_pkg::TotalW'(1);
    end
  end

  // Persistent state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) fill_q[i] <= '0;
      total_q        <= '0;
      adds_q         <= '0;
      stopped_q      <= 1'b0;
      out_valid_o    <= 1'b0;
      status_o       <= '0;
      taken_handle_o <= '0;
      queued_total_o <= '0;
      added_count_o  <= '0;
    end else begin
      if (fill_we) begin
        fill_q[fill_lv] <= fill_wd;
      end
      total_q   <= total_d;
      adds_q    <= adds_d;
      stopped_q <= stopped_d;
      if (res_load) begin
        out_valid_o    <= 1'b1;
        status_o       <= res_status;
        taken_handle_o <= res_taken;
        queued_total_o <= total_d;
        added_count_o  <= adds_d;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> cur_fill != '0)
    else $error("removal from an empty level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> out_valid_o && status_o == sptq_pkg::StOk)
    else $error("accepted add did not report ok");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide || cmd_i.miss || cmd_i.finish) |-> !out_valid_o)
    else $error("result overwrote a pending result");

endmodule

[rtl/core/strict_priority_task_queue.sv]
// Strict priority task queue.
// Input channel: in_valid_i / in_ready_o carry kind_i, task_handle_i and
// priority_level_i. Kinds are add, take, cancel and stop.
// Output channel: out_valid_o / out_ready_i carry one result per input
// transfer: status_o, taken_handle_o, queued_total_o and added_count_o.
// Items are worked one at a time. Add, stop, a take with every level empty
// and a cancel at an invalid or empty level need no search and are resolved
// in the decide state, which registers the result. Take and cancel read the
// slot memory through one port: a take reads the oldest slot of the first
// held level and then compacts the level one slot a cycle; a cancel reads
// slots from the oldest (position 0) until one matches and then compacts
// the rest, and one that misses reads every held slot. A new input is taken
// only once the result has been accepted and the sequencer is idle again.
// When the receiver stalls, the result is held unchanged and no further
// input is taken. Reset empties every level, clears the add count and the
// stopped flag; slot contents are not cleared and need no sweep.
module strict_priority_task_queue #(
  parameter int unsigned Levels     = sptq_pkg::LevelsDefault,
  parameter int unsigned LevelDepth = sptq_pkg::LevelDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sptq_pkg::KindW-1:0]    kind_i,
  input  logic [sptq_pkg::HandleW-1:0]  task_handle_i,
  input  logic [sptq_pkg::PrioW-1:0]    priority_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sptq_pkg::StatusW-1:0]  status_o,
  output logic [sptq_pkg::HandleW-1:0]  taken_handle_o,
  output logic [sptq_pkg::TotalW-1:0]   queued_total_o,
  output logic [sptq_pkg::CountW-1:0]   added_count_o
);

  sptq_pkg::sptq_cmd_t  cmd;
  sptq_pkg::sptq_stat_t stat;

  // Sequencer.
  sptq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_i (out_valid_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Level storage and result register.
  sptq_datapath #(
    .Levels     (Levels),
    .LevelDepth (LevelDepth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .task_handle_i    (task_handle_i),
    .priority_level_i (priority_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .taken_handle_o   (taken_handle_o),
    .queued_total_o   (queued_total_o),
    .added_count_o    (added_count_o)
  );

endmodule
